[hdl/rwlt_pkg.sv]
package rwlt_pkg;

    // Request and result field widths.
    localparam int OPCODE_W      = 3;
    localparam int LOCK_INDEX_W  = 8;
    localparam int INCARNATION_W = 32;
    localparam int READERS_W     = 31;
    localparam int WORD_W        = 64;

    // Stream data widths, padded to whole bytes.
    localparam int S_FIELDS_W = OPCODE_W + LOCK_INDEX_W + INCARNATION_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + INCARNATION_W + READERS_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Position of the writer bit inside a lock word.
    localparam int WRITER_BIT = READERS_W;

    typedef logic [OPCODE_W-1:0]      opcode_t;
    typedef logic [WORD_W-1:0]        lock_word_t;
    typedef logic [INCARNATION_W-1:0] incarnation_t;

    // Operation codes.
    localparam opcode_t OP_ACQUIRE_READ  = 3'd0;
    localparam opcode_t OP_UPGRADE       = 3'd1;
    localparam opcode_t OP_SET_WRITE     = 3'd2;
    localparam opcode_t OP_RELEASE_READ  = 3'd3;
    localparam opcode_t OP_RELEASE_WRITE = 3'd4;
    localparam opcode_t OP_RELEASE_DEL   = 3'd5;

    // Addends applied to a whole lock word with modular arithmetic.
    localparam lock_word_t WORD_READER_ONE = 64'h0000_0000_0000_0001;
    localparam lock_word_t WORD_WRITER_ONE = 64'h0000_0000_8000_0000;
    localparam lock_word_t WORD_READER_NEG = 64'h0 - WORD_READER_ONE;
    localparam lock_word_t WORD_WRITER_NEG = 64'h0 - WORD_WRITER_ONE;

    // Low halves of a word held by one reader and by the writer.
    localparam incarnation_t LOW_ONE_READER = 32'h0000_0001;
    localparam incarnation_t LOW_WRITER     = 32'h8000_0000;

endpackage

[hdl/reader_writer_lock_table_unit.sv]
// Reader/writer lock table. Each request on the slave stream names one lock
// word and one operation; the block updates that word and returns exactly one
// result on the master stream, in request order, carrying the grant flag and
// the incarnation, reader count and writer bit as they stood before the
// request. The table is zero after reset without any clearing pass: a valid
// bit per entry makes a never-written word read as zero. One request is taken
// every clock cycle unless a stalled result holds requests off. A request
// passes through the registered read of the lock table and the update stage,
// which registers the result, with the word being written forwarded to a
// request for the same lock that follows right behind. Lock indexes at or
// beyond LOCK_COUNT wrap modulo LOCK_COUNT.
module reader_writer_lock_table_unit #(
    parameter int LOCK_COUNT = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // opcode[2:0], lock_index[10:3], expected_incarnation[42:11], zero pad
    input  logic [rwlt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // granted[0], incarnation_seen[32:1], readers_seen[63:33],
    // writer_seen[64], zero pad
    output logic [rwlt_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import rwlt_pkg::*;

    localparam int INDEX_SPAN = 1 << LOCK_INDEX_W;
    localparam int DEPTH      = (LOCK_COUNT < INDEX_SPAN) ? LOCK_COUNT : INDEX_SPAN;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Request fields.
    opcode_t                 in_opcode;
    logic [LOCK_INDEX_W-1:0] in_index;
    incarnation_t            in_expect;
    logic                    in_fire;
    logic [IDX_W-1:0]        rd_slot;

    // Constant table folding an index onto the table depth.
    logic [IDX_W-1:0]        slot_map [INDEX_SPAN];

    // Lock table and its per-entry valid bits.
    lock_word_t              lock_mem [DEPTH];
    logic [DEPTH-1:0]        valid_reg;

    // Update stage.
    logic                    s1_valid_reg;
    opcode_t                 s1_opcode_reg;
    logic [IDX_W-1:0]        s1_slot_reg;
    incarnation_t            s1_expect_reg;
    lock_word_t              rd_data_reg;
    logic                    rd_hit_reg;
    logic                    fwd_hit_reg;
    lock_word_t              fwd_data_reg;
    logic                    s1_fire;

    lock_word_t              word_before;
    lock_word_t              word_addend;
    lock_word_t              word_sum;
    lock_word_t              word_after;
    logic                    granted;

    // Result register.
    logic                    out_valid_reg;
    logic [M_TDATA_W-1:0]    out_tdata_reg;
    logic [M_TDATA_W-1:0]    out_tdata_next;

    assign in_opcode = s_axis_tdata[OPCODE_W-1:0];
    assign in_index  = s_axis_tdata[OPCODE_W +: LOCK_INDEX_W];
    assign in_expect = s_axis_tdata[OPCODE_W + LOCK_INDEX_W +: INCARNATION_W];

    // Index wrap table, worked out at elaboration.
    for (genvar g = 0; g < INDEX_SPAN; g++) begin : gen_slot_map
        assign slot_map[g] = IDX_W'(g % LOCK_COUNT);
    end

    assign rd_slot = slot_map[in_index];

    // The update stage moves on when the result register is free or drains.
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Word before the update: forwarded write, stored word, or reset zero.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            word_before = fwd_data_reg;
        end
        else if (rd_hit_reg)
        begin
            word_before = rd_data_reg;
        end
        else
        begin
            word_before = '0;
        end
    end

    // Addend for the shared word adder.
    always_comb
    begin
        case (s1_opcode_reg) inside
            OP_ACQUIRE_READ:                  word_addend = WORD_READER_ONE;
            OP_SET_WRITE, OP_RELEASE_DEL:     word_addend = WORD_WRITER_ONE;
            OP_RELEASE_READ:                  word_addend = WORD_READER_NEG;
            OP_RELEASE_WRITE:                 word_addend = WORD_WRITER_NEG;
            default:                          word_addend = '0;
        endcase
    end

    assign word_sum = word_before + word_addend;

    // Operation decode: grant and new word.
    always_comb
    begin
        word_after = word_before;
        granted    = 1'b0;
        unique case (s1_opcode_reg) inside
            OP_ACQUIRE_READ:
            begin
                if (!word_before[WRITER_BIT])
                begin
                    word_after = word_sum;
                    granted    = 1'b1;
                end
            end
            OP_UPGRADE:
            begin
                if (word_before == {s1_expect_reg, LOW_ONE_READER})
                begin
                    word_after = {s1_expect_reg, LOW_WRITER};
                    granted    = 1'b1;
                end
            end
            OP_SET_WRITE, OP_RELEASE_READ, OP_RELEASE_WRITE, OP_RELEASE_DEL:
            begin
                word_after = word_sum;
                granted    = 1'b1;
            end
            default:
            begin
                word_after = word_before;
                granted    = 1'b0;
            end
        endcase
    end

    assign out_tdata_next = {{M_PAD_W{1'b0}},
                             word_before[WRITER_BIT],
                             word_before[READERS_W-1:0],
                             word_before[WORD_W-1:WORD_W-INCARNATION_W],
                             granted};

    // Table storage: write on update, registered read on request transfer.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            lock_mem[s1_slot_reg] <= word_after;
        end
        if (in_fire)
        begin
            rd_data_reg <= lock_mem[rd_slot];
        end
    end

    // Valid bits and pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                valid_reg[s1_slot_reg] <= 1'b1;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload, valid-bit read and forwarding of the word being written.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_opcode_reg <= in_opcode;
            s1_slot_reg   <= rd_slot;
            s1_expect_reg <= in_expect;
            rd_hit_reg    <= valid_reg[rd_slot];
            fwd_hit_reg   <= s1_fire && (s1_slot_reg == rd_slot);
            fwd_data_reg  <= word_after;
        end
        if (s1_fire)
        begin
            out_tdata_reg <= out_tdata_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;

endmodule

[hdl/rwlt_checker.sv]
module rwlt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [rwlt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [rwlt_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rwlt_pkg::*;

    logic       in_xfer;
    logic       out_xfer;
    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Requests transferred in whose results are not yet transferred out.
    always_comb
    begin
        pending_next = pending_reg + {2'b00, in_xfer} - {2'b00, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result holds its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // At most the update stage and the result register hold requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("too many requests in flight");

    // No result without an outstanding request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("result without request");

    // Requests are only held off by a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("request stalled without output back-pressure");

endmodule

bind reader_writer_lock_table_unit rwlt_checker u_rwlt_checker (.*);
